### hw/rtl/smaa_pkg.sv
// ----------------------------------------------------------------------------
// smaa_pkg
// shared constants and the fixed-point cosine helpers
// ----------------------------------------------------------------------------
package smaa_pkg;

    localparam logic [17:0] HalfPiQ16 = 18'd102944;
    localparam logic [18:0] DegToRadQ24 = 19'd292818;
    localparam logic [15:0] SunAmpQ16 = 16'd26811;
    localparam logic [15:0] MoonAmpQ16 = 16'd30243;
    localparam int AltLimit = 25736;
    // reciprocal of 365 scaled by 2^54, rounded up
    localparam logic [45:0] Recip365 = 46'd49354516464335;

    localparam logic [0:0] RegLat = 1'b0;
    localparam logic [0:0] RegLon = 1'b1;

    typedef struct packed {
        logic        moon;
        logic [15:0] frac;
        logic [15:0] lon;
    } t_ctl;

    // quarter-wave fold: magnitude argument and sign of the cosine
    function automatic logic [16:0] cos_arg(input logic [15:0] a);
        logic [1:0]  q;
        logic [13:0] r;
        begin
            q = a[15:14];
            r = a[13:0];
            if (q == 2'd0 || q == 2'd2) cos_arg = 17'((15'd16384 - 15'(r)) << 2);
            else cos_arg = 17'({r, 2'b00});
        end
    endfunction

    function automatic logic cos_neg(input logic [15:0] a);
        cos_neg = (a[15:14] == 2'd1) || (a[15:14] == 2'd2);
    endfunction

endpackage

### hw/rtl/smaa_cos.sv
// ----------------------------------------------------------------------------
// smaa_cos
// pipelined q16 cosine of a turn angle, five register stages, sideband rides along
// ----------------------------------------------------------------------------
module smaa_cos (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [15:0]  i_angle,
    input  logic [63:0]  i_side,
    output logic         o_valid,
    output logic signed [17:0] o_cos,
    output logic [63:0]  o_side
);
    import smaa_pkg::*;

    logic [4:0]  r_v;
    logic [63:0] r_s [5];
    logic        r_neg [4];
    logic [16:0] r_u [4];
    logic [16:0] r_u2 [2];
    logic [15:0] r_t1;
    logic [16:0] r_t2;
    logic [16:0] n_t3;
    logic [33:0] n_u2;
    logic [32:0] n_t1;
    logic [32:0] n_t2;
    logic [35:0] n_t4;
    logic [17:0] n_mag;
    logic signed [17:0] r_out;

    always_comb begin
        n_u2 = r_u[0] * r_u[0];
        n_t1 = 33'(16'd4640 * r_u2[0]);
        n_t2 = 33'((16'd42047 - r_t1) * r_u2[1]);
        n_t3 = 17'(18'd102944 - 18'(r_t2));
        n_t4 = n_t3 * 19'(r_u[3]);
        n_mag = (n_t4[35:16] > 20'd65536) ? 18'd65536 : n_t4[33:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s[0] <= i_side;
            r_neg[0] <= cos_neg(i_angle);
            r_u[0] <= cos_arg(i_angle);
            for (int k = 1; k < 5; k++) r_s[k] <= r_s[k-1];
            for (int k = 1; k < 4; k++) begin
                r_neg[k] <= r_neg[k-1];
                r_u[k] <= r_u[k-1];
            end
            r_u2[0] <= n_u2[32:16];
            r_u2[1] <= r_u2[0];
            r_t1 <= n_t1[31:16];
            r_t2 <= n_t2[32:16];
            r_out <= r_neg[3] ? -$signed(n_mag) : $signed(n_mag);
        end
    end

    assign o_valid = r_v[4];
    assign o_cos = r_out;
    assign o_side = r_s[4];
endmodule

### hw/rtl/sun_moon_altitude_azimuth.sv
// ----------------------------------------------------------------------------
// sun_moon_altitude_azimuth
// sun or moon altitude and azimuth from day number and time of day
// ----------------------------------------------------------------------------
// Accepts one word per cycle while the output register is empty or its word is taken;
// each result passes through the phase stages, the declination cosine, the altitude
// mix, the azimuth cosine and the output blend. A full pipeline stalls as a whole
// when the output word is not taken. Configure only while idle.
module sun_moon_altitude_azimuth (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // day_index[8:0], day_fraction[24:9]
    input  logic        s_axis_tuser,   // 1 selects the moon, 0 the sun
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // azimuth[15:0], altitude[31:16]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import smaa_pkg::*;

    logic signed [15:0] r_lat_cfg;
    logic [15:0] r_lon_cfg;
    logic signed [18:0] r_lat_rad;
    logic en;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_cfg <= '0;
            r_lon_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                RegLat: r_lat_cfg <= pwdata[15:0];
                RegLon: r_lon_cfg <= pwdata[15:0];
                default: ;
            endcase
        end
    end
    always_comb prdata = (paddr[2] == RegLon) ? {16'd0, r_lon_cfg} : {{16{r_lat_cfg[15]}}, r_lat_cfg};

    logic signed [35:0] lat_prod;
    assign lat_prod = r_lat_cfg * $signed({1'b0, DegToRadQ24});
    always_ff @(posedge i_clk) r_lat_rad <= 19'(lat_prod >>> 16);

    // output register with global stall
    logic r_ov;
    logic [31:0] r_od;
    assign en = !r_ov || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_od;

    // stage p0: numerator
    logic r_p0v, r_p1v, r_p2v;
    logic [28:0] r_num, r_lnum;
    t_ctl r_c0, r_c1, r_c2;
    logic [24:0] d;
    assign d = {s_axis_tdata[8:0], s_axis_tdata[24:9]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) {r_p0v, r_p1v, r_p2v} <= '0;
        else if (en) {r_p0v, r_p1v, r_p2v} <= {s_axis_tvalid, r_p0v, r_p1v};
    end

    // stage p1: reciprocal products (partial), p2: combine
    logic [51:0] r_ph_lo, r_lp_lo;
    logic [51:0] r_ph_hi, r_lp_hi;
    logic [31:0] r_phase, r_lon32;
    logic [69:0] ph_full, lp_full;
    always_comb begin
        ph_full = 70'(r_ph_lo) + (70'(r_ph_hi) << 23);
        lp_full = 70'(r_lp_lo) + (70'(r_lp_hi) << 23);
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num <= s_axis_tuser ? 29'(d * 4'd12) : 29'(d + 25'(10 << 16));
            r_lnum <= 29'(d * 4'd11);
            r_c0 <= '{moon: s_axis_tuser, frac: d[15:0], lon: r_lon_cfg};
            r_ph_lo <= 52'(r_num * Recip365[22:0]);
            r_ph_hi <= 52'(r_num * Recip365[45:23]);
            r_lp_lo <= 52'(r_lnum * Recip365[22:0]);
            r_lp_hi <= 52'(r_lnum * Recip365[45:23]);
            r_c1 <= r_c0;
            r_phase <= ph_full[69:38];
            r_lon32 <= lp_full[69:38];
            r_c2 <= r_c1;
        end
    end

    logic [15:0] az;
    logic [31:0] az32;
    assign az32 = {r_c2.frac, 16'd0} + r_lon32 + {r_c2.lon, 16'd0};
    assign az = r_c2.moon ? az32[31:16] : r_c2.frac;

    logic dv;
    logic signed [17:0] dcos;
    logic [63:0] dside;
    smaa_cos u_dec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_p2v),
        .i_angle(r_phase[31:16]), .i_side({47'd0, r_c2.moon, az}),
        .o_valid(dv), .o_cos(dcos), .o_side(dside)
    );

    // declination and noon/midnight extremes
    logic r_m0v, r_m1v;
    logic signed [19:0] r_dec;
    logic [15:0] r_az0, r_az1;
    logic signed [35:0] dprod;
    logic signed [20:0] sum_ld, dif_ld;
    logic signed [20:0] r_max, r_min;
    logic r_mirror;
    assign dprod = -($signed({1'b0, dside[16] ? MoonAmpQ16 : SunAmpQ16}) * dcos);
    assign sum_ld = r_lat_rad + r_dec;
    assign dif_ld = r_lat_rad - r_dec;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) {r_m0v, r_m1v} <= '0;
        else if (en) {r_m0v, r_m1v} <= {dv, r_m0v};
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dec <= 20'(dprod >>> 16);
            r_az0 <= dside[15:0];
            r_max <= 21'($signed({3'd0, HalfPiQ16})) - (dif_ld < 0 ? -dif_ld : dif_ld);
            r_min <= (sum_ld < 0 ? -sum_ld : sum_ld) - 21'($signed({3'd0, HalfPiQ16}));
            r_mirror <= sum_ld <= 0;
            r_az1 <= r_az0;
        end
    end

    logic av;
    logic signed [17:0] acos;
    logic [63:0] aside;
    smaa_cos u_az (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_m1v),
        .i_angle(r_az1 - 16'h8000),
        .i_side({5'd0, r_mirror, r_max, r_min, r_az1}),
        .o_valid(av), .o_cos(acos), .o_side(aside)
    );

    logic signed [20:0] amax, amin;
    logic signed [40:0] bprod;
    logic signed [22:0] ssum, alt;
    logic [15:0] azo;
    logic signed [15:0] alto;
    always_comb begin
        amax = aside[57:37];
        amin = aside[36:16];
        bprod = (amax - amin) * acos;
        ssum = 23'(amax) + 23'(amin) + 23'(bprod >>> 16);
        alt = ssum >>> 3;
        if (alt > AltLimit) alto = 16'(AltLimit);
        else if (alt < -AltLimit) alto = -16'(AltLimit);
        else alto = alt[15:0];
        azo = aside[58] ? 16'h8000 - aside[15:0] : aside[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en) r_ov <= av;
    end
    always_ff @(posedge i_clk) begin
        if (en) r_od <= {alto, azo};
    end

    a_alt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[31:16]) <= AltLimit &&
                           $signed(m_axis_tdata[31:16]) >= -AltLimit))
        else $error("altitude out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output changed");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
endmodule
